// ===== rtl/itoa_pkg.sv =====
// Shared types, character codes and helpers for the integer to ASCII formatter.
package itoa_pkg;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned NUM_DIG  = 10;
  localparam int unsigned BCD_W    = NUM_DIG * DIGIT_W;
  localparam int unsigned CNT_W    = 4;
  localparam int unsigned CHAR_W   = 7;

  localparam logic [CNT_W-1:0] DEC_DIGITS = CNT_W'(10);
  localparam logic [CNT_W-1:0] HEX_DIGITS = CNT_W'(8);

  localparam logic [1:0] OP_UNSIGNED = 2'd0;
  localparam logic [1:0] OP_SIGNED   = 2'd1;
  localparam logic [1:0] OP_HEX      = 2'd2;
  localparam logic [1:0] OP_NONE     = 2'd3;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_LOW_A = 7'h61;
  localparam logic [CHAR_W-1:0] CHAR_X     = 7'h78;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [1:0]         operation;
  } in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } out_t;

  typedef struct packed {
    logic [BCD_W-1:0] digits;
    logic             hex;
    logic             neg;
  } emit_cmd_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] r;
    if (d < DIGIT_W'(10)) begin
      r = CHAR_ZERO + CHAR_W'(d);
    end else begin
      r = CHAR_LOW_A - CHAR_W'(10) + CHAR_W'(d);
    end
    return r;
  endfunction

endpackage

// ===== rtl/itoa_dabble.sv =====
// Bit-serial binary to BCD converter using shift-and-add-3, one bit per cycle.
module itoa_dabble (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [itoa_pkg::VALUE_W-1:0] mag_i,
  output logic                         done_o,
  output logic [itoa_pkg::BCD_W-1:0]   bcd_o
);

  logic [itoa_pkg::VALUE_W-1:0] bin_q, bin_d;
  logic [itoa_pkg::BCD_W-1:0]   bcd_q, bcd_d, adj;
  logic [5:0]                   cnt_q, cnt_d;
  logic                         run_q, run_d;
  logic                         done_q, done_d;

  always_comb begin
    for (int i = 0; i < int'(itoa_pkg::NUM_DIG); i++) begin
      if (bcd_q[i*itoa_pkg::DIGIT_W +: itoa_pkg::DIGIT_W] >= itoa_pkg::DIGIT_W'(5)) begin
        adj[i*itoa_pkg::DIGIT_W +: itoa_pkg::DIGIT_W] =
          bcd_q[i*itoa_pkg::DIGIT_W +: itoa_pkg::DIGIT_W] + itoa_pkg::DIGIT_W'(3);
      end else begin
        adj[i*itoa_pkg::DIGIT_W +: itoa_pkg::DIGIT_W] =
          bcd_q[i*itoa_pkg::DIGIT_W +: itoa_pkg::DIGIT_W];
      end
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      bin_d = mag_i;
      bcd_d = '0;
      cnt_d = 6'(itoa_pkg::VALUE_W);
      run_d = 1'b1;
    end else if (run_q) begin
      bcd_d = {adj[itoa_pkg::BCD_W-2:0], bin_q[itoa_pkg::VALUE_W-1]};
      bin_d = {bin_q[itoa_pkg::VALUE_W-2:0], 1'b0};
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

// ===== rtl/itoa_emit.sv =====
// Character emitter: prefix, leading-zero skip and one digit per cycle when not stalled, into the output register.
module itoa_emit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  itoa_pkg::emit_cmd_t cmd_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output itoa_pkg::out_t      out_data_o,
  output logic                done_o
);

  typedef enum logic [2:0] {
    E_IDLE,
    E_MINUS,
    E_ZERO,
    E_X,
    E_DIGITS
  } state_e;

  state_e                        state_q, state_d;
  logic [itoa_pkg::BCD_W-1:0]    dig_q, dig_d;
  logic [itoa_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic                          seen_q, seen_d;
  logic                          out_valid_q, out_valid_d;
  itoa_pkg::out_t                out_q, out_d;
  logic                          done_q, done_d;
  logic                          load_ok;
  logic [itoa_pkg::DIGIT_W-1:0]  top_dig;

  assign load_ok = !out_valid_q || !out_stall_i;
  assign top_dig = dig_q[itoa_pkg::BCD_W-1 -: itoa_pkg::DIGIT_W];

  always_comb begin
    state_d     = state_q;
    dig_d       = dig_q;
    cnt_d       = cnt_q;
    seen_d      = seen_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    done_d      = 1'b0;
    unique case (state_q)
      E_IDLE: begin
        if (start_i) begin
          dig_d  = cmd_i.digits;
          cnt_d  = cmd_i.hex ? itoa_pkg::HEX_DIGITS : itoa_pkg::DEC_DIGITS;
          seen_d = 1'b0;
          if (cmd_i.neg) begin
            state_d = E_MINUS;
          end else if (cmd_i.hex) begin
            state_d = E_ZERO;
          end else begin
            state_d = E_DIGITS;
          end
        end
      end
      E_MINUS: begin
        if (load_ok) begin
          out_valid_d = 1'b1;
          out_d       = '{character: itoa_pkg::CHAR_MINUS, last: 1'b0};
          state_d     = E_DIGITS;
        end
      end
      E_ZERO: begin
        if (load_ok) begin
          out_valid_d = 1'b1;
          out_d       = '{character: itoa_pkg::CHAR_ZERO, last: 1'b0};
          state_d     = E_X;
        end
      end
      E_X: begin
        if (load_ok) begin
          out_valid_d = 1'b1;
          out_d       = '{character: itoa_pkg::CHAR_X, last: 1'b0};
          state_d     = E_DIGITS;
        end
      end
      E_DIGITS: begin
        if (!seen_q && top_dig == '0 && cnt_q != itoa_pkg::CNT_W'(1)) begin
          dig_d = {dig_q[itoa_pkg::BCD_W-itoa_pkg::DIGIT_W-1:0], itoa_pkg::DIGIT_W'(0)};
          cnt_d = cnt_q - itoa_pkg::CNT_W'(1);
        end else if (load_ok) begin
          out_valid_d = 1'b1;
          out_d       = '{character: itoa_pkg::digit_char(top_dig),
                          last: (cnt_q == itoa_pkg::CNT_W'(1))};
          dig_d  = {dig_q[itoa_pkg::BCD_W-itoa_pkg::DIGIT_W-1:0], itoa_pkg::DIGIT_W'(0)};
          cnt_d  = cnt_q - itoa_pkg::CNT_W'(1);
          seen_d = 1'b1;
          if (cnt_q == itoa_pkg::CNT_W'(1)) begin
            state_d = E_IDLE;
            done_d  = 1'b1;
          end
        end
      end
      default: state_d = E_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= E_IDLE;
      cnt_q       <= '0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
      done_q      <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q <= dig_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign done_o      = done_q;

endmodule

// ===== rtl/integer_to_ascii_digits.sv =====
// Decimal: bit-serial BCD conversion, handoff to the emitter, leading-zero skip, then the characters.
// Hexadecimal: handoff to the emitter, leading-zero skip, then the characters (no conversion).
// One item at a time: the bit-serial BCD shifter and the digit shift register set the pace.
// Operation code 3 is dropped on acceptance.
// Reset (rst_ni low, asynchronous) empties the output register and returns to idle.
module integer_to_ascii_digits (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  itoa_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output itoa_pkg::out_t out_data_o
);

  logic                         busy_q, busy_d;
  logic                         neg_q, neg_d;
  logic                         accept;
  logic                         is_hex;
  logic                         is_none;
  logic                         is_neg;
  logic [itoa_pkg::VALUE_W-1:0] mag;
  logic                         dab_done;
  logic [itoa_pkg::BCD_W-1:0]   dab_bcd;
  logic                         emit_start;
  itoa_pkg::emit_cmd_t          emit_cmd;
  logic                         emit_done;

  assign accept  = in_valid_i && !busy_q;
  assign is_hex  = in_data_i.operation == itoa_pkg::OP_HEX;
  assign is_none = in_data_i.operation == itoa_pkg::OP_NONE;
  assign is_neg  = in_data_i.operation == itoa_pkg::OP_SIGNED
                   && in_data_i.value[itoa_pkg::VALUE_W-1];
  assign mag     = is_neg ? (~in_data_i.value + itoa_pkg::VALUE_W'(1)) : in_data_i.value;

  always_comb begin
    busy_d = busy_q;
    neg_d  = neg_q;
    if (emit_done) begin
      busy_d = 1'b0;
    end else if (accept && !is_none) begin
      busy_d = 1'b1;
      neg_d  = is_neg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      neg_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      neg_q  <= neg_d;
    end
  end

  itoa_dabble u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept && !is_none && !is_hex),
    .mag_i   (mag),
    .done_o  (dab_done),
    .bcd_o   (dab_bcd)
  );

  always_comb begin
    emit_start = dab_done || (accept && is_hex);
    if (dab_done) begin
      emit_cmd = '{digits: dab_bcd, hex: 1'b0, neg: neg_q};
    end else begin
      emit_cmd = '{digits: {in_data_i.value,
                            (itoa_pkg::BCD_W - itoa_pkg::VALUE_W)'(0)},
                   hex: 1'b1, neg: 1'b0};
    end
  end

  itoa_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (emit_start),
    .cmd_i       (emit_cmd),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .done_o      (emit_done)
  );

  assign in_stall_o = busy_q;

endmodule

// ===== rtl/itoa_checker.sv =====
// Port-level checks for the integer to ASCII formatter, bound to the top level.
module itoa_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input itoa_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input itoa_pkg::out_t out_data_o
);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.operation != itoa_pkg::OP_NONE |=> in_stall_o)
    else $error("stall not raised after a transaction");

  a_drop_unused_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.operation == itoa_pkg::OP_NONE |=> !in_stall_o)
    else $error("unused operation left the block busy");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output transaction changed");

  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.character >= itoa_pkg::CHAR_MINUS
                    && out_data_o.character <= itoa_pkg::CHAR_X)
    else $error("output character out of range");

endmodule

bind integer_to_ascii_digits itoa_checker u_itoa_checker (.*);
